### rtl/tlssni_pkg.sv
// Shared types and constants for the TLS ClientHello server-name extractor.
package tlssni_pkg;

  localparam int unsigned OFFSET_W = 17;
  localparam int unsigned LENGTH_W = 16;
  localparam int unsigned STATUS_W = 3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_FOUND      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_HOST    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MALFORMED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_HELLO  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 3'd4;

  // Header and handshake constants
  localparam logic [7:0] CT_HANDSHAKE    = 8'h16;
  localparam logic [7:0] VER_MAJOR       = 8'h03;
  localparam logic [7:0] VER_MINOR_MAX   = 8'h04;
  localparam logic [7:0] HS_CLIENT_HELLO = 8'h01;

  localparam int unsigned HDR_LEN          = 5;
  localparam int unsigned HELLO_FIXED_SKIP = 37;  // length, version, random
  localparam int unsigned HELLO_MIN_END    = 44;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFFSET_W-1:0] host_offset;
    logic [LENGTH_W-1:0] host_length;
  } res_t;

endpackage

### rtl/tlssni_byte_if.sv
// Payload byte channel: valid/ready handshake carrying one byte and a last flag.
interface tlssni_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last;

  modport source (output valid, output payload_byte, output last, input ready);
  modport sink   (input valid, input payload_byte, input last, output ready);
endinterface

### rtl/tlssni_res_if.sv
// Result channel: valid/ready handshake carrying status, host offset and length.
interface tlssni_res_if;
  logic                               valid;
  logic                               ready;
  logic [tlssni_pkg::STATUS_W-1:0]    status;
  logic [tlssni_pkg::OFFSET_W-1:0]    host_offset;
  logic [tlssni_pkg::LENGTH_W-1:0]    host_length;

  modport source (output valid, output status, output host_offset, output host_length,
                  input ready);
  modport sink   (input valid, input status, input host_offset, input host_length,
                  output ready);
endinterface

### rtl/tlssni_parser.sv
// Byte-at-a-time ClientHello walker: per-packet state and result on the last byte.
module tlssni_parser #(
  parameter int unsigned POSITION_BITS = 17
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               acc_i,
  input  logic [7:0]         byte_i,
  input  logic               last_i,
  output logic               res_valid_o,
  output tlssni_pkg::res_t   res_o
);
  import tlssni_pkg::*;

  localparam int unsigned PB = POSITION_BITS;
  localparam int unsigned CW = ((PB > OFFSET_W) ? PB : OFFSET_W) + 2;
  localparam logic [PB-1:0] PosMax = '1;

  typedef enum logic [3:0] {
    PH_DONE, PH_HDR, PH_HS_TYPE, PH_SID_LEN, PH_CS_HI, PH_CS_LO, PH_CM_LEN,
    PH_EXT_HI, PH_EXT_LO, PH_EX_T0, PH_EX_T1, PH_EX_L0, PH_EX_L1,
    PH_SN_TYPE, PH_SN_HI, PH_SN_LO
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [PB-1:0]         pos_q, pos_d;
  logic [LENGTH_W-1:0]   skip_q, skip_d;
  logic [OFFSET_W-1:0]   rec_q, rec_d;
  logic [OFFSET_W-1:0]   ee_q, ee_d;
  logic [OFFSET_W-1:0]   cee_q, cee_d;
  logic [7:0]            lhb_q, lhb_d;
  logic [OFFSET_W-1:0]   fo_q, fo_d;
  logic [LENGTH_W-1:0]   fl_q, fl_d;
  logic [STATUS_W-1:0]   lat_q, lat_d;
  logic                  kz_q, kz_d;
  logic                  check_types_q;

  logic [CW-1:0]         pos_x, pos_p1, n_b, n_l, ext_nx, sn_nx;
  logic [LENGTH_W-1:0]   len16, ext_sk, sn_sk;
  logic                  do_ext, do_sn;
  logic [STATUS_W-1:0]   st;

  assign len16  = {lhb_q, byte_i};
  assign pos_x  = CW'(pos_q);
  assign pos_p1 = pos_x + CW'(1);
  assign n_b    = pos_p1 + CW'(byte_i);
  assign n_l    = pos_p1 + CW'(len16);

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    skip_d  = skip_q;
    rec_d   = rec_q;
    ee_d    = ee_q;
    cee_d   = cee_q;
    lhb_d   = lhb_q;
    fo_d    = fo_q;
    fl_d    = fl_q;
    lat_d   = lat_q;
    kz_d    = kz_q;
    do_ext  = 1'b0;
    do_sn   = 1'b0;
    ext_nx  = '0;
    sn_nx   = '0;
    ext_sk  = '0;
    sn_sk   = '0;
    st      = lat_q;
    res_valid_o = 1'b0;
    res_o   = '0;

    if (acc_i) begin
      if (pos_q != PosMax) pos_d = pos_q + PB'(1);

      if (phase_q != PH_DONE) begin
        if (skip_q != '0) begin
          skip_d = skip_q - LENGTH_W'(1);
        end else begin
          case (phase_q)
            PH_HDR: begin
              if (pos_q == PB'(0)) begin
                if (check_types_q && byte_i != CT_HANDSHAKE) begin
                  lat_d = ST_NOT_HELLO; phase_d = PH_DONE;
                end
              end else if (pos_q == PB'(1)) begin
                if (check_types_q && byte_i != VER_MAJOR) begin
                  lat_d = ST_NOT_HELLO; phase_d = PH_DONE;
                end
              end else if (pos_q == PB'(2)) begin
                if (check_types_q && byte_i > VER_MINOR_MAX) begin
                  lat_d = ST_NOT_HELLO; phase_d = PH_DONE;
                end
              end else if (pos_q == PB'(3)) begin
                lhb_d = byte_i;
              end else begin
                rec_d = OFFSET_W'(HDR_LEN) + OFFSET_W'(len16);
                if (len16 == '0) begin
                  lat_d = ST_MALFORMED; phase_d = PH_DONE;
                end else begin
                  phase_d = PH_HS_TYPE;
                end
              end
            end
            PH_HS_TYPE: begin
              if (check_types_q && byte_i != HS_CLIENT_HELLO) begin
                lat_d = ST_NOT_HELLO; phase_d = PH_DONE;
              end else if (rec_q < OFFSET_W'(HELLO_MIN_END)) begin
                lat_d = ST_MALFORMED; phase_d = PH_DONE;
              end else begin
                skip_d = LENGTH_W'(HELLO_FIXED_SKIP);
                phase_d = PH_SID_LEN;
              end
            end
            PH_SID_LEN: begin
              if (n_b + CW'(2) > CW'(rec_q)) begin
                lat_d = ST_MALFORMED; phase_d = PH_DONE;
              end else begin
                skip_d = LENGTH_W'(byte_i); phase_d = PH_CS_HI;
              end
            end
            PH_CS_HI: begin
              lhb_d = byte_i; phase_d = PH_CS_LO;
            end
            PH_CS_LO: begin
              if (n_l + CW'(1) > CW'(rec_q)) begin
                lat_d = ST_MALFORMED; phase_d = PH_DONE;
              end else begin
                skip_d = len16; phase_d = PH_CM_LEN;
              end
            end
            PH_CM_LEN: begin
              if (n_b + CW'(2) > CW'(rec_q)) begin
                lat_d = ST_MALFORMED; phase_d = PH_DONE;
              end else begin
                skip_d = LENGTH_W'(byte_i); phase_d = PH_EXT_HI;
              end
            end
            PH_EXT_HI: begin
              lhb_d = byte_i; phase_d = PH_EXT_LO;
            end
            PH_EXT_LO: begin
              if (n_l > CW'(rec_q)) begin
                lat_d = ST_MALFORMED; phase_d = PH_DONE;
              end else begin
                ee_d   = n_l[OFFSET_W-1:0];
                do_ext = 1'b1;
                ext_nx = pos_p1;
                ext_sk = '0;
              end
            end
            PH_EX_T0: begin
              kz_d = (byte_i == 8'd0); phase_d = PH_EX_T1;
            end
            PH_EX_T1: begin
              kz_d = kz_q && (byte_i == 8'd0); phase_d = PH_EX_L0;
            end
            PH_EX_L0: begin
              lhb_d = byte_i; phase_d = PH_EX_L1;
            end
            PH_EX_L1: begin
              if (kz_q) begin
                if (n_l > CW'(ee_q)) begin
                  lat_d = ST_MALFORMED; phase_d = PH_DONE;
                end else begin
                  // skip the 2-byte server-name list length unchecked
                  cee_d = n_l[OFFSET_W-1:0];
                  do_sn = 1'b1;
                  sn_nx = pos_x + CW'(3);
                  sn_sk = LENGTH_W'(2);
                end
              end else begin
                do_ext = 1'b1;
                ext_nx = n_l;
                ext_sk = len16;
              end
            end
            PH_SN_TYPE: begin
              kz_d = (byte_i == 8'd0); phase_d = PH_SN_HI;
            end
            PH_SN_HI: begin
              lhb_d = byte_i; phase_d = PH_SN_LO;
            end
            PH_SN_LO: begin
              if (n_l > CW'(cee_q)) begin
                lat_d = ST_MALFORMED; phase_d = PH_DONE;
              end else if (kz_q) begin
                fo_d = pos_p1[OFFSET_W-1:0];
                fl_d = len16;
                lat_d = ST_FOUND; phase_d = PH_DONE;
              end else begin
                do_sn = 1'b1;
                sn_nx = n_l;
                sn_sk = len16;
              end
            end
            default: begin
            end
          endcase

          if (do_ext) begin
            if (ext_nx + CW'(4) <= CW'(ee_d)) begin
              skip_d = ext_sk; phase_d = PH_EX_T0;
            end else if (ext_nx != CW'(ee_d)) begin
              lat_d = ST_MALFORMED; phase_d = PH_DONE;
            end else begin
              lat_d = ST_NO_HOST; phase_d = PH_DONE;
            end
          end

          if (do_sn) begin
            if (sn_nx + CW'(4) <= CW'(cee_d)) begin
              skip_d = sn_sk; phase_d = PH_SN_TYPE;
            end else if (sn_nx != CW'(cee_d)) begin
              lat_d = ST_MALFORMED; phase_d = PH_DONE;
            end else begin
              lat_d = ST_NO_HOST; phase_d = PH_DONE;
            end
          end
        end
      end

      if (last_i) begin
        // partial header first; then not-a-hello; then short record; then the parse
        if (pos_d < PB'(HDR_LEN)) st = ST_INCOMPLETE;
        else if (phase_d == PH_DONE && lat_d == ST_NOT_HELLO) st = ST_NOT_HELLO;
        else if (CW'(pos_d) < CW'(rec_d)) st = ST_INCOMPLETE;
        else st = lat_d;

        res_valid_o       = 1'b1;
        res_o.status      = st;
        res_o.host_offset = (st == ST_FOUND) ? fo_d : '0;
        res_o.host_length = (st == ST_FOUND) ? fl_d : '0;

        phase_d = PH_HDR;
        pos_d   = '0;
        skip_d  = '0;
        rec_d   = '0;
        ee_d    = '0;
        cee_d   = '0;
        lhb_d   = '0;
        fo_d    = '0;
        fl_d    = '0;
        lat_d   = ST_NO_HOST;
        kz_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_HDR;
      pos_q         <= '0;
      skip_q        <= '0;
      rec_q         <= '0;
      ee_q          <= '0;
      cee_q         <= '0;
      lhb_q         <= '0;
      fo_q          <= '0;
      fl_q          <= '0;
      lat_q         <= ST_NO_HOST;
      kz_q          <= 1'b0;
      check_types_q <= 1'b1;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      skip_q  <= skip_d;
      rec_q   <= rec_d;
      ee_q    <= ee_d;
      cee_q   <= cee_d;
      lhb_q   <= lhb_d;
      fo_q    <= fo_d;
      fl_q    <= fl_d;
      lat_q   <= lat_d;
      kz_q    <= kz_d;
      if (cfg_we_i) check_types_q <= cfg_wdata_i;
    end
  end

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && last_i |=> phase_q == PH_HDR && pos_q == '0 && lat_q == ST_NO_HOST)
    else $error("per-packet state not cleared after last byte");

  a_found_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status == ST_FOUND |-> res_o.host_offset != '0)
    else $error("found result without a host offset");

  a_other_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status != ST_FOUND |->
      res_o.host_offset == '0 && res_o.host_length == '0)
    else $error("non-found result carries host fields");

  a_header_no_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HDR |-> skip_q == '0 && pos_q < PB'(HDR_LEN))
    else $error("header phase with skip or past header");

endmodule

### rtl/tlssni_out_queue.sv
// Two-entry result queue between the parser and the result channel.
module tlssni_out_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tlssni_pkg::res_t push_data_i,
  output logic             not_full_o,
  output logic             valid_o,
  input  logic             ready_i,
  output tlssni_pkg::res_t data_o
);
  import tlssni_pkg::*;

  res_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       pop;

  assign pop        = valid_o && ready_i;
  assign valid_o    = (count_q != 2'd0);
  assign not_full_o = (count_q != 2'd2);
  assign data_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(push_i) - 2'(pop);
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("result queue count out of range");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> not_full_o)
    else $error("push into full result queue");

  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd1) == (wr_ptr_q != rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule

### rtl/tls_client_hello_sni_extractor.sv
// Top level of the TLS ClientHello server-name extractor.
//
// pkt_i carries the TCP payload of one packet, one byte per transaction,
// starting at the TLS record header, with last set on the final byte.
// res_o carries one result per packet: status (0 found, 1 no host name,
// 2 malformed bounds, 3 not a client hello, 4 incomplete record) and the
// payload offset and length of the host name when found.
// cfg_we_i / cfg_wdata_i write check_types (reset 1); write only while idle.
//
// Throughput: one byte per cycle unless the queue is full. Each byte is parsed
// in the cycle it is accepted; a packet's result enters a two-entry queue as its
// last byte is accepted and reaches res_o once earlier results are taken, so
// bytes keep flowing while one result waits; pkt_i.ready drops only when two
// results are waiting on a stalled receiver.
// Reset clears the parser to the record header, empties the queue and sets
// check_types to 1.
module tls_client_hello_sni_extractor #(
  parameter int unsigned POSITION_BITS = 17
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cfg_we_i,
  input  logic  cfg_wdata_i,
  tlssni_byte_if.sink  pkt_i,
  tlssni_res_if.source res_o
);
  import tlssni_pkg::*;

  logic acc;
  logic not_full;
  logic res_valid;
  res_t res;
  res_t q_data;

  assign pkt_i.ready = not_full;
  assign acc         = pkt_i.valid && not_full;

  tlssni_parser #(
    .POSITION_BITS (POSITION_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .acc_i       (acc),
    .byte_i      (pkt_i.payload_byte),
    .last_i      (pkt_i.last),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tlssni_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .not_full_o  (not_full),
    .valid_o     (res_o.valid),
    .ready_i     (res_o.ready),
    .data_o      (q_data)
  );

  assign res_o.status      = q_data.status;
  assign res_o.host_offset = q_data.host_offset;
  assign res_o.host_length = q_data.host_length;

endmodule

### tb/testbench.sv
// Self-checking testbench for the TLS ClientHello server-name extractor.
`timescale 1ns / 1ps

module testbench;
  import tlssni_pkg::*;

  localparam int unsigned POS_BITS = 17;
  localparam logic [POS_BITS-1:0] POS_SAT = '1;

  typedef enum logic [3:0] {
    W_DONE, W_REC_HDR, W_HS_TYPE, W_SID_LEN, W_CS_HI, W_CS_LO, W_CM_LEN, W_EXT_HI,
    W_EXT_LO, W_X_T0, W_X_T1, W_X_L0, W_X_L1, W_SN_TYPE, W_SN_HI, W_SN_LO
  } walk_phase_e;

  typedef struct {
    int         sid_n;
    int         cs_n;
    int         cm_n;
    int         ext_pre;
    int         ext_post;
    int         pad_n;
    bit         sni;
    int         ent_pre;
    int         name_n;
    int         ext_junk;
    int         sn_junk;
    logic [7:0] minor;
  } hello_shape_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  tlssni_byte_if pkt_if ();
  tlssni_res_if  res_if ();

  // sniffer model state
  walk_phase_e           walk_phase;
  logic [POS_BITS-1:0]   bytes_seen;
  int unsigned           skip_left;
  int unsigned           rec_end;
  int unsigned           ext_end;
  int unsigned           sni_end;
  logic [7:0]            hi_byte;
  int unsigned           hit_offset;
  int unsigned           hit_length;
  logic [STATUS_W-1:0]   walk_status;
  bit                    kind_zero;
  bit                    types_checked;

  res_t        expected_results[$];
  logic [7:0]  frame[$];
  int          at_sid, at_cs, at_cm, at_ext, at_sni, at_host;

  bit          sender_idle;
  bit          sink_idle;
  int unsigned stall_left;
  int unsigned error_count;
  int unsigned bytes_sent;
  int unsigned packets_sent;
  int unsigned results_checked;
  int unsigned config_writes;
  int unsigned status_seen[5];

  tls_client_hello_sni_extractor #(
    .POSITION_BITS(POS_BITS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .pkt_i      (pkt_if),
    .res_o      (res_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_walk();
    walk_phase  = W_REC_HDR;
    bytes_seen  = '0;
    skip_left   = 0;
    rec_end     = 0;
    ext_end     = 0;
    sni_end     = 0;
    hi_byte     = '0;
    hit_offset  = 0;
    hit_length  = 0;
    walk_status = ST_NO_HOST;
    kind_zero   = 1'b0;
  endfunction

  function automatic void conclude(logic [STATUS_W-1:0] st);
    walk_status = st;
    walk_phase  = W_DONE;
  endfunction

  function automatic void next_extension(int unsigned nxt, int unsigned skip);
    if (nxt + 4 <= ext_end) begin
      skip_left  = skip;
      walk_phase = W_X_T0;
    end else if (nxt != ext_end) begin
      conclude(ST_MALFORMED);
    end else begin
      conclude(ST_NO_HOST);
    end
  endfunction

  function automatic void next_entry(int unsigned nxt, int unsigned skip);
    if (nxt + 4 <= sni_end) begin
      skip_left  = skip;
      walk_phase = W_SN_TYPE;
    end else if (nxt != sni_end) begin
      conclude(ST_MALFORMED);
    end else begin
      conclude(ST_NO_HOST);
    end
  endfunction

  function automatic void walk_byte(int unsigned p, logic [7:0] b);
    int unsigned len;
    int unsigned n;
    len = 32'({hi_byte, b});
    case (walk_phase)
      W_REC_HDR: begin
        case (p)
          0: if (types_checked && b != CT_HANDSHAKE) conclude(ST_NOT_HELLO);
          1: if (types_checked && b != VER_MAJOR) conclude(ST_NOT_HELLO);
          2: if (types_checked && b > VER_MINOR_MAX) conclude(ST_NOT_HELLO);
          3: hi_byte = b;
          default: begin
            rec_end = HDR_LEN + len;
            if (rec_end < HDR_LEN + 1) conclude(ST_MALFORMED);
            else walk_phase = W_HS_TYPE;
          end
        endcase
      end
      W_HS_TYPE: begin
        if (types_checked && b != HS_CLIENT_HELLO) begin
          conclude(ST_NOT_HELLO);
        end else if (HELLO_MIN_END > rec_end) begin
          conclude(ST_MALFORMED);
        end else begin
          skip_left  = HELLO_FIXED_SKIP;
          walk_phase = W_SID_LEN;
        end
      end
      W_SID_LEN: begin
        n = p + 1 + 32'(b);
        if (n + 2 > rec_end) begin
          conclude(ST_MALFORMED);
        end else begin
          skip_left  = 32'(b);
          walk_phase = W_CS_HI;
        end
      end
      W_CS_HI: begin
        hi_byte    = b;
        walk_phase = W_CS_LO;
      end
      W_CS_LO: begin
        n = p + 1 + len;
        if (n + 1 > rec_end) begin
          conclude(ST_MALFORMED);
        end else begin
          skip_left  = len;
          walk_phase = W_CM_LEN;
        end
      end
      W_CM_LEN: begin
        n = p + 1 + 32'(b);
        if (n + 2 > rec_end) begin
          conclude(ST_MALFORMED);
        end else begin
          skip_left  = 32'(b);
          walk_phase = W_EXT_HI;
        end
      end
      W_EXT_HI: begin
        hi_byte    = b;
        walk_phase = W_EXT_LO;
      end
      W_EXT_LO: begin
        ext_end = p + 1 + len;
        if (ext_end > rec_end) conclude(ST_MALFORMED);
        else next_extension(p + 1, 0);
      end
      W_X_T0: begin
        kind_zero  = (b == 8'h00);
        walk_phase = W_X_T1;
      end
      W_X_T1: begin
        kind_zero  = kind_zero && (b == 8'h00);
        walk_phase = W_X_L0;
      end
      W_X_L0: begin
        hi_byte    = b;
        walk_phase = W_X_L1;
      end
      W_X_L1: begin
        n = p + 1 + len;
        if (!kind_zero) begin
          next_extension(n, len);
        end else if (n > ext_end) begin
          conclude(ST_MALFORMED);
        end else begin
          // server-name list length is skipped without a check
          sni_end = n;
          next_entry(p + 3, 2);
        end
      end
      W_SN_TYPE: begin
        kind_zero  = (b == 8'h00);
        walk_phase = W_SN_HI;
      end
      W_SN_HI: begin
        hi_byte    = b;
        walk_phase = W_SN_LO;
      end
      W_SN_LO: begin
        n = p + 1 + len;
        if (n > sni_end) begin
          conclude(ST_MALFORMED);
        end else if (kind_zero) begin
          hit_offset = p + 1;
          hit_length = len;
          conclude(ST_FOUND);
        end else begin
          next_entry(n, len);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic lst);
    int unsigned         p;
    logic [STATUS_W-1:0] st;
    res_t                r;
    p = 32'(bytes_seen);
    if (bytes_seen != POS_SAT) bytes_seen++;
    if (walk_phase != W_DONE) begin
      if (skip_left > 0) skip_left--;
      else walk_byte(p, b);
    end
    if (!lst) return;
    // not-a-hello outranks an incomplete record unless the header is partial
    if (32'(bytes_seen) < HDR_LEN) st = ST_INCOMPLETE;
    else if (walk_phase == W_DONE && walk_status == ST_NOT_HELLO) st = ST_NOT_HELLO;
    else if (32'(bytes_seen) < rec_end) st = ST_INCOMPLETE;
    else st = walk_status;
    r.status      = st;
    r.host_offset = (st == ST_FOUND) ? hit_offset[OFFSET_W-1:0] : '0;
    r.host_length = (st == ST_FOUND) ? hit_length[LENGTH_W-1:0] : '0;
    expected_results.insert(expected_results.size(), r);
    clear_walk();
  endfunction

  // ---------------------------------------------------------------- checker

  function automatic void check_result();
    res_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result: status %0d offset %0d length %0d", $time,
               res_if.status, res_if.host_offset, res_if.host_length);
      error_count++;
      return;
    end
    want = expected_results.pop_front();
    results_checked++;
    if (want.status <= ST_INCOMPLETE) status_seen[want.status]++;
    if (res_if.status !== want.status) begin
      $display("%0t: status mismatch: expected %0d, actual %0d", $time,
               want.status, res_if.status);
      error_count++;
    end
    if (res_if.host_offset !== want.host_offset) begin
      $display("%0t: host_offset mismatch: expected %0d, actual %0d", $time,
               want.host_offset, res_if.host_offset);
      error_count++;
    end
    if (res_if.host_length !== want.host_length) begin
      $display("%0t: host_length mismatch: expected %0d, actual %0d", $time,
               want.host_length, res_if.host_length);
      error_count++;
    end
  endfunction

  // result transactions are checked on the edge that accepts them
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) check_result();
    if (stall_left > 0) begin
      stall_left--;
      res_if.ready <= 1'b0;
    end else if (sink_idle && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 10);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- frame builders

  function automatic void append_byte(ref logic [7:0] q[$], input logic [7:0] v);
    q.insert(q.size(), v);
  endfunction

  function automatic void put16(ref logic [7:0] q[$], input int unsigned v);
    append_byte(q, v[15:8]);
    append_byte(q, v[7:0]);
  endfunction

  function automatic void frame_from(logic [63:0] word, int count);
    frame.delete();
    for (int i = count - 1; i >= 0; i--) append_byte(frame, word[8*i +: 8]);
  endfunction

  function automatic void add_plain_ext(ref logic [7:0] q[$]);
    int unsigned t;
    int unsigned n;
    t = $urandom_range(1, 65535);
    // partial-zero types must not be taken for server_name
    case ($urandom_range(0, 3))
      0: t = t & 32'h00FF;
      1: t = t & 32'hFF00;
      default: ;
    endcase
    if (t == 0) t = 32'h0023;
    n = $urandom_range(0, 8);
    put16(q, t);
    put16(q, n);
    repeat (n) append_byte(q, 8'($urandom));
  endfunction

  function automatic void make_hello(hello_shape_t s);
    logic [7:0]  body[$];
    logic [7:0]  exts[$];
    logic [7:0]  names[$];
    int unsigned sni_rel;
    int unsigned host_rel;
    int unsigned n;
    append_byte(body, HS_CLIENT_HELLO);
    repeat (3) append_byte(body, 8'($urandom));
    append_byte(body, VER_MAJOR);
    append_byte(body, 8'h03);
    repeat (32) append_byte(body, 8'($urandom));
    at_sid = HDR_LEN + body.size();
    append_byte(body, 8'(s.sid_n));
    repeat (s.sid_n) append_byte(body, 8'($urandom));
    at_cs = HDR_LEN + body.size();
    put16(body, s.cs_n);
    repeat (s.cs_n) append_byte(body, 8'($urandom));
    at_cm = HDR_LEN + body.size();
    append_byte(body, 8'(s.cm_n));
    repeat (s.cm_n) append_byte(body, 8'($urandom));
    repeat (s.ext_pre) add_plain_ext(exts);
    if (s.pad_n > 0) begin
      put16(exts, 32'h0015);
      put16(exts, s.pad_n);
      repeat (s.pad_n) append_byte(exts, 8'h00);
    end
    sni_rel  = 0;
    host_rel = 0;
    if (s.sni) begin
      repeat (s.ent_pre) begin
        append_byte(names, 8'($urandom_range(1, 255)));
        n = $urandom_range(0, 5);
        put16(names, n);
        repeat (n) append_byte(names, 8'($urandom));
      end
      host_rel = names.size();
      append_byte(names, 8'h00);
      put16(names, s.name_n);
      repeat (s.name_n) append_byte(names, 8'($urandom_range(97, 122)));
      repeat (s.sn_junk) append_byte(names, 8'($urandom));
      sni_rel = exts.size();
      put16(exts, 32'h0000);
      put16(exts, names.size() + 2);
      put16(exts, names.size());
      foreach (names[i]) append_byte(exts, names[i]);
    end
    repeat (s.ext_post) add_plain_ext(exts);
    repeat (s.ext_junk) append_byte(exts, 8'($urandom));
    at_ext  = HDR_LEN + body.size();
    at_sni  = s.sni ? at_ext + 2 + sni_rel + 2 : -1;
    at_host = s.sni ? at_ext + 2 + sni_rel + 6 + host_rel : -1;
    put16(body, exts.size());
    foreach (exts[i]) append_byte(body, exts[i]);
    frame.delete();
    append_byte(frame, CT_HANDSHAKE);
    append_byte(frame, VER_MAJOR);
    append_byte(frame, s.minor);
    put16(frame, body.size());
    foreach (body[i]) append_byte(frame, body[i]);
  endfunction

  function automatic hello_shape_t base_shape();
    hello_shape_t s;
    s.sid_n    = 8;
    s.cs_n     = 4;
    s.cm_n     = 1;
    s.ext_pre  = 1;
    s.ext_post = 1;
    s.pad_n    = 0;
    s.sni      = 1'b1;
    s.ent_pre  = 0;
    s.name_n   = 11;
    s.ext_junk = 0;
    s.sn_junk  = 0;
    s.minor    = 8'h03;
    return s;
  endfunction

  function automatic hello_shape_t random_shape();
    hello_shape_t s;
    s.sid_n    = ($urandom_range(0, 7) == 0) ? 32 : $urandom_range(0, 8);
    s.cs_n     = $urandom_range(0, 6);
    s.cm_n     = $urandom_range(0, 2);
    s.ext_pre  = $urandom_range(0, 2);
    s.ext_post = $urandom_range(0, 2);
    s.pad_n    = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : 0;
    s.sni      = ($urandom_range(0, 4) != 0);
    s.ent_pre  = $urandom_range(0, 2);
    s.name_n   = $urandom_range(0, 20);
    s.ext_junk = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
    s.sn_junk  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
    s.minor    = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
    return s;
  endfunction

  function automatic void make_noise();
    int n;
    n = $urandom_range(1, 48);
    frame.delete();
    repeat (n) append_byte(frame, 8'($urandom));
    if (n >= 5 && $urandom_range(0, 1) == 1) begin
      frame[0] = CT_HANDSHAKE;
      frame[1] = VER_MAJOR;
      frame[2] = 8'($urandom_range(0, 4));
      frame[3] = 8'h00;
    end
  endfunction

  function automatic void corrupt_length();
    int idx[$];
    int k;
    idx = '{3, 4, at_sid, at_cs, at_cs + 1, at_cm, at_ext, at_ext + 1};
    if (at_sni >= 0) begin
      idx.insert(idx.size(), at_sni);
      idx.insert(idx.size(), at_sni + 1);
      idx.insert(idx.size(), at_host + 1);
      idx.insert(idx.size(), at_host + 2);
    end
    k = idx[$urandom_range(0, idx.size() - 1)];
    if ($urandom_range(0, 1) == 1) frame[k] = 8'($urandom);
    else frame[k] = frame[k] + 8'($urandom_range(1, 3));
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_byte(logic [7:0] b, logic lst);
    if (sender_idle && $urandom_range(0, 7) == 0) begin
      pkt_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    pkt_if.valid        <= 1'b1;
    pkt_if.payload_byte <= b;
    pkt_if.last         <= lst;
    do @(posedge clk_i); while (!pkt_if.ready);
    bytes_sent++;
    predict_byte(b, lst);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame.size(); i++) send_byte(frame[i], i == frame.size() - 1);
    packets_sent++;
  endtask

  task automatic drain_results();
    pkt_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  task automatic write_check_types(logic v);
    drain_results();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    types_checked = v;
    config_writes++;
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_found();
    hello_shape_t s;
    s = base_shape();
    make_hello(s);
    send_frame();
    s.minor   = 8'h00;
    s.ent_pre = 2;
    s.ext_pre = 2;
    make_hello(s);
    send_frame();
    s = base_shape();
    s.minor  = VER_MINOR_MAX;
    s.sid_n  = 32;
    s.name_n = 0;
    make_hello(s);
    send_frame();
  endtask

  task automatic test_no_host();
    hello_shape_t s;
    s = base_shape();
    s.sni = 1'b0;
    make_hello(s);
    send_frame();
    s = base_shape();
    make_hello(s);
    frame[at_host] = 8'h02;
    send_frame();
    s.sni      = 1'b0;
    s.ext_pre  = 0;
    s.ext_post = 0;
    make_hello(s);
    send_frame();
  endtask

  task automatic test_header();
    hello_shape_t s;
    frame_from(64'h00, 1);
    send_frame();
    frame_from(64'h16_03_03_00, 4);
    send_frame();
    // empty record
    frame_from(64'h16_03_03_00_00, 5);
    send_frame();
    // record too short for the fixed hello fields
    frame_from(64'h16_03_03_00_03_01_00_00, 8);
    send_frame();
    s = base_shape();
    make_hello(s);
    frame[0] = 8'h17;
    send_frame();
    make_hello(s);
    frame[1] = 8'h02;
    send_frame();
    make_hello(s);
    frame[2] = VER_MINOR_MAX + 8'd1;
    send_frame();
    // wrong handshake type wins over the truncation
    make_hello(s);
    frame[5] = 8'h02;
    while (frame.size() > 10) frame.pop_back();
    send_frame();
    make_hello(s);
    frame.pop_back();
    send_frame();
    make_hello(s);
    repeat (7) append_byte(frame, 8'hFF);
    send_frame();
  endtask

  task automatic test_bounds();
    hello_shape_t s;
    s = base_shape();
    make_hello(s);
    frame[at_sid] = 8'hFF;
    send_frame();
    make_hello(s);
    frame[at_cs] = 8'hFF;
    send_frame();
    make_hello(s);
    frame[at_cm] = 8'hFF;
    send_frame();
    make_hello(s);
    frame[at_ext] = frame[at_ext] + 8'd1;
    send_frame();
    make_hello(s);
    frame[at_sni] = 8'hFF;
    send_frame();
    make_hello(s);
    frame[at_host + 1] = 8'hFF;
    send_frame();
    // extensions block with a tail too short for another header
    s.ext_junk = 2;
    make_hello(s);
    send_frame();
    // name list with leftover bytes and no hostname entry
    s = base_shape();
    s.sn_junk = 3;
    make_hello(s);
    frame[at_host] = 8'h07;
    send_frame();
  endtask

  task automatic test_long_records();
    hello_shape_t s;
    sender_idle = 1'b0;
    // host name long enough that every enclosing length needs its high byte
    s = base_shape();
    s.name_n = 300;
    make_hello(s);
    send_frame();
    sender_idle = 1'b1;
  endtask

  task automatic test_types_off();
    hello_shape_t s;
    write_check_types(1'b0);
    s = base_shape();
    make_hello(s);
    frame[0] = 8'h17;
    frame[1] = 8'h00;
    frame[2] = 8'hFF;
    frame[5] = 8'h02;
    send_frame();
  endtask

  task automatic test_random(int unsigned min_bytes, int unsigned min_pkts);
    int unsigned  bytes0;
    int unsigned  pkts0;
    int unsigned  cut;
    hello_shape_t s;
    bytes0 = bytes_sent;
    pkts0  = packets_sent;
    while (bytes_sent - bytes0 < min_bytes || packets_sent - pkts0 < min_pkts) begin
      s = random_shape();
      make_hello(s);
      case ($urandom_range(0, 19))
        12, 13: begin
          cut = $urandom_range(1, frame.size());
          while (frame.size() > cut) frame.pop_back();
        end
        14, 15: repeat ($urandom_range(1, 8)) append_byte(frame, 8'($urandom));
        16: frame[$urandom_range(0, 5)] = 8'($urandom);
        17: frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom);
        18: make_noise();
        19: corrupt_length();
        default: ;
      endcase
      send_frame();
      if ($urandom_range(0, 24) == 0) drain_results();
    end
  endtask

  task automatic finish_run();
    int unsigned waited;
    pkt_if.valid <= 1'b0;
    waited = 0;
    while (expected_results.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      error_count += expected_results.size();
    end
    $display("Sent %0d packets (%0d bytes), checked %0d results, %0d check_types writes",
             packets_sent, bytes_sent, results_checked, config_writes);
    $display("Outcomes: found %0d, no host %0d, malformed %0d, not hello %0d, incomplete %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  endtask

  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_wdata_i         = 1'b0;
    pkt_if.valid        = 1'b0;
    pkt_if.payload_byte = 8'h00;
    pkt_if.last         = 1'b0;
    res_if.ready        = 1'b0;
    sender_idle         = 1'b1;
    sink_idle           = 1'b1;
    stall_left          = 0;
    error_count         = 0;
    bytes_sent          = 0;
    packets_sent        = 0;
    results_checked     = 0;
    config_writes       = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    types_checked       = 1'b1;
    clear_walk();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_found();
    test_no_host();
    test_header();
    test_bounds();
    test_long_records();
    test_types_off();
    test_random(200, 8);
    write_check_types(1'b1);
    test_random(200, 8);
    // closing stretch runs at full rate on both sides
    sender_idle = 1'b0;
    sink_idle   = 1'b0;
    test_random(200, 8);
    finish_run();
  end

endmodule

### tls_client_hello_sni_extractor.f
rtl/tlssni_pkg.sv
rtl/tlssni_byte_if.sv
rtl/tlssni_res_if.sv
rtl/tlssni_parser.sv
rtl/tlssni_out_queue.sv
rtl/tls_client_hello_sni_extractor.sv
tb/testbench.sv
